### rtl/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared constants, register codes, result type and bin quantizer for the
// gray co-occurrence matrix unit.
// ----------------------------------------------------------------------------
package gcm_pkg;

  // default sizing of the unit
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_BINS   = 256;

  // field widths
  localparam int PIX_W   = 8;
  localparam int BIN_W   = 8;
  localparam int DIM_W   = 11;
  localparam int CNT_W   = 32;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;

  // register reset values
  localparam logic [BIN_W-1:0] RST_BIN_COUNT    = 8'd10;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

  // item codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // register word index
  typedef enum logic [1:0] {
    REG_BIN_COUNT    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  // per-pixel update slots: (left,q) (q,left) (up,q) (q,up)
  localparam logic [3:0] OP_LEFT_FWD = 4'b0001;
  localparam logic [3:0] OP_LEFT_REV = 4'b0010;
  localparam logic [3:0] OP_UP_FWD   = 4'b0100;
  localparam logic [3:0] OP_UP_REV   = 4'b1000;

  // one result beat
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             frame_done;
  } res_t;

  // bin = floor((p*n + 127) / 255), n = bins - 1; divide by 255 done as
  // (y + 1 + (y >> 8)) >> 8, exact for y below 65535
  function automatic logic [BIN_W-1:0] quant_bin(input logic [PIX_W-1:0] pix,
                                                 input logic [BIN_W-1:0] nm1);
    logic [15:0] prod;
    logic [16:0] y;
    logic [16:0] s;
    prod = 16'(pix) * 16'(nm1);
    y    = 17'(prod) + 17'd127;
    s    = y + 17'd1 + 17'(y[16:8]);
    return s[15:8];
  endfunction

endpackage

### rtl/gray_cooccurrence_matrix_unit.sv
// ----------------------------------------------------------------------------
// gray_cooccurrence_matrix_unit
// Symmetric co-occurrence histogram of quantized gray pixels over right and
// lower neighbors, held in one count memory with read-modify-write updates.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------------
//  in      | input     | in_valid/in_stall | in_func in_pixel in_row_bin in_col_bin
//  out     | output    | out_valid/out_stall| out_count out_frame_done
//  cfg     | input     | psel/penable/pready| paddr pwdata pwrite, prdata back
//
//  pixel beat: one count update per cycle on the single count memory port (the
//    last waits on a full output queue): four for an interior pixel, two on the
//    first row or column, none at frame start; each result passes two registers.
//  reset clears the count memory (2**(2*clog2(MAX_BINS)) entries, 65536 by
//    default) and the line store in one pass.
//  the first pixel of a frame waits for a clearing pass over the count memory
//    unless no pixel has been taken since the last pass; the input is stalled
//    during a pass, config writes still land.
//  out_stall backs up through a two-beat output queue into in_stall.
//
module gray_cooccurrence_matrix_unit #(
  parameter int MAX_WIDTH  = gcm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gcm_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BINS   = gcm_pkg::DEF_MAX_BINS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [gcm_pkg::PIX_W-1:0]   in_pixel,
  input  logic [gcm_pkg::BIN_W-1:0]   in_row_bin,
  input  logic [gcm_pkg::BIN_W-1:0]   in_col_bin,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gcm_pkg::CNT_W-1:0]   out_count,
  output logic                        out_frame_done,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcm_pkg::APB_AW-1:0]  paddr,
  input  logic [gcm_pkg::APB_DW-1:0]  pwdata,
  output logic [gcm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int BW        = $clog2(MAX_BINS);
  localparam int CAW       = 2 * BW;
  localparam int CNT_DEPTH = 1 << CAW;
  localparam int UAW       = $clog2(MAX_WIDTH);
  localparam int RPW       = $clog2(MAX_HEIGHT);
  localparam int WPW       = $clog2(MAX_WIDTH + 1);
  localparam int HPW       = $clog2(MAX_HEIGHT + 1);
  localparam int WXW       = (WPW > gcm_pkg::DIM_W) ? WPW : gcm_pkg::DIM_W;
  localparam int HXW       = (HPW > gcm_pkg::DIM_W) ? HPW : gcm_pkg::DIM_W;
  localparam int CLW       = (CAW > UAW) ? CAW : UAW;
  localparam int RST_LEN   = (CNT_DEPTH > MAX_WIDTH) ? CNT_DEPTH : MAX_WIDTH;

  localparam int CW  = gcm_pkg::CNT_W;
  localparam int BNW = gcm_pkg::BIN_W;
  localparam int DW  = gcm_pkg::DIM_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [BNW-1:0] bin_count_r;
  logic [DW-1:0]  width_r;
  logic [DW-1:0]  height_r;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= gcm_pkg::RST_BIN_COUNT;
      width_r     <= gcm_pkg::RST_IMAGE_WIDTH;
      height_r    <= gcm_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_wr) begin
      unique case (gcm_pkg::cfg_reg_t'(paddr[3:2]))
        gcm_pkg::REG_BIN_COUNT:    bin_count_r <= pwdata[BNW-1:0];
        gcm_pkg::REG_IMAGE_WIDTH:  width_r     <= pwdata[DW-1:0];
        gcm_pkg::REG_IMAGE_HEIGHT: height_r    <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (gcm_pkg::cfg_reg_t'(paddr[3:2]))
      gcm_pkg::REG_BIN_COUNT:    prdata = gcm_pkg::APB_DW'(bin_count_r);
      gcm_pkg::REG_IMAGE_WIDTH:  prdata = gcm_pkg::APB_DW'(width_r);
      gcm_pkg::REG_IMAGE_HEIGHT: prdata = gcm_pkg::APB_DW'(height_r);
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // effective bins and frame geometry
  // --------------------------------------------------------------------------
  logic [8:0]     bins_eff;
  logic [8:0]     bins_nm1_w;
  logic [BNW-1:0] bins_nm1;
  logic [WXW-1:0] width_x;
  logic [WXW-1:0] w_eff;
  logic [HXW-1:0] height_x;
  logic [HXW-1:0] h_eff;

  always_comb begin
    if (bin_count_r == '0) begin
      bins_eff = 9'd1;
    end else if (9'(bin_count_r) > 9'(MAX_BINS)) begin
      bins_eff = 9'(MAX_BINS);
    end else begin
      bins_eff = 9'(bin_count_r);
    end
    bins_nm1_w = bins_eff - 9'd1;
    bins_nm1   = bins_nm1_w[BNW-1:0];

    width_x = WXW'(width_r);
    if (width_x == '0) begin
      w_eff = WXW'(1);
    end else if (width_x > WXW'(MAX_WIDTH)) begin
      w_eff = WXW'(MAX_WIDTH);
    end else begin
      w_eff = width_x;
    end

    height_x = HXW'(height_r);
    if (height_x == '0) begin
      h_eff = HXW'(1);
    end else if (height_x > HXW'(MAX_HEIGHT)) begin
      h_eff = HXW'(MAX_HEIGHT);
    end else begin
      h_eff = height_x;
    end
  end

  // --------------------------------------------------------------------------
  // raster position, quantizer and accept
  // --------------------------------------------------------------------------
  logic [UAW-1:0] col_pos_r;
  logic [RPW-1:0] row_pos_r;
  logic [BW-1:0]  left_r;
  logic [UAW-1:0] col_pos_nxt;
  logic [RPW-1:0] row_pos_nxt;
  logic [WXW-1:0] col_inc;
  logic [HXW-1:0] row_inc;
  logic           col_wrap;
  logic           row_wrap;
  logic           at_origin;
  logic [BNW-1:0] q_full;
  logic [BW-1:0]  q;
  logic           rd_ok;
  logic           clean_r;
  logic           clr_act_r;
  logic           need_clr;
  logic           start_clr;
  logic           a_vld_r;
  logic           a_fin;
  logic           in_acc;
  logic           pix_acc;

  always_comb begin
    q_full    = gcm_pkg::quant_bin(in_pixel, bins_nm1);
    q         = q_full[BW-1:0];
    rd_ok     = (bin_count_r != '0) && (9'(in_row_bin) < bins_eff) &&
                (9'(in_col_bin) < bins_eff);
    at_origin = (row_pos_r == '0) && (col_pos_r == '0);

    col_inc  = WXW'(col_pos_r) + WXW'(1);
    row_inc  = HXW'(row_pos_r) + HXW'(1);
    col_wrap = col_inc >= w_eff;
    row_wrap = row_inc >= h_eff;

    col_pos_nxt = col_wrap ? '0 : col_inc[UAW-1:0];
    row_pos_nxt = row_pos_r;
    if (col_wrap) begin
      row_pos_nxt = row_wrap ? '0 : row_inc[RPW-1:0];
    end
  end

  // a frame's first pixel on dirty counts waits for a clearing pass
  assign need_clr  = in_valid && (in_func == gcm_pkg::FUNC_PIXEL) && at_origin && !clean_r;
  assign start_clr = need_clr && !a_vld_r && !clr_act_r;
  assign in_stall  = clr_act_r || (a_vld_r && !a_fin) || need_clr;
  assign in_acc    = in_valid && !in_stall;
  assign pix_acc   = in_acc && (in_func == gcm_pkg::FUNC_PIXEL);

  // position and left neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      left_r    <= '0;
    end else if (pix_acc) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      left_r    <= q;
    end
  end

  // --------------------------------------------------------------------------
  // clearing pass over count memory (and line store after reset)
  // --------------------------------------------------------------------------
  logic           clr_up_r;
  logic [CLW-1:0] clr_cnt_r;
  logic [CLW-1:0] clr_last;
  logic           up_clr_we;

  assign clr_last  = clr_up_r ? CLW'(RST_LEN - 1) : CLW'(CNT_DEPTH - 1);
  assign up_clr_we = clr_act_r && clr_up_r &&
                     ({1'b0, clr_cnt_r} < (CLW + 1)'(MAX_WIDTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_up_r  <= 1'b1;
      clr_cnt_r <= '0;
      clean_r   <= 1'b0;
    end else if (clr_act_r) begin
      clr_cnt_r <= clr_cnt_r + CLW'(1);
      if (clr_cnt_r == clr_last) begin
        clr_act_r <= 1'b0;
        clr_up_r  <= 1'b0;
        clean_r   <= 1'b1;
      end
    end else if (start_clr) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (pix_acc) begin
      clean_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // line store of upper-row bins, read old and write new on pixel accept
  // --------------------------------------------------------------------------
  logic [BW-1:0] up_mem [MAX_WIDTH];
  logic [BW-1:0] up_rd_r;

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      up_rd_r            <= up_mem[col_pos_r];
      up_mem[col_pos_r]  <= q;
    end else if (up_clr_we) begin
      up_mem[clr_cnt_r[UAW-1:0]] <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // job stage: one accepted item, issues its count updates (the last only with output queue room) one per cycle
  // --------------------------------------------------------------------------
  logic           a_func_r;
  logic [BW-1:0]  a_q_r;
  logic [BW-1:0]  a_left_r;
  logic [3:0]     a_mask_r;
  logic           a_rd_ok_r;
  logic [CAW-1:0] a_rd_addr_r;
  logic           a_done_r;
  logic [3:0]     op_oh;
  logic [3:0]     mask_rest;
  logic           a_last;
  logic [CAW-1:0] op_addr;
  logic           is_bump;
  logic           is_read;
  logic           issue;
  logic           mem_rd_en;
  logic           credit_ok;
  logic [2:0]     occ;
  logic [1:0]     fill_r;
  logic           w_res_r;
  logic           pop;

  always_comb begin
    op_oh     = a_mask_r & (~a_mask_r + 4'd1);
    mask_rest = a_mask_r & ~op_oh;
    a_last    = mask_rest == '0;
    case (op_oh)
      gcm_pkg::OP_LEFT_FWD: op_addr = {a_left_r, a_q_r};
      gcm_pkg::OP_LEFT_REV: op_addr = {a_q_r, a_left_r};
      gcm_pkg::OP_UP_FWD:   op_addr = {up_rd_r, a_q_r};
      gcm_pkg::OP_UP_REV:   op_addr = {a_q_r, up_rd_r};
      default:              op_addr = a_rd_addr_r;
    endcase
    is_bump = (a_func_r == gcm_pkg::FUNC_PIXEL) && (a_mask_r != '0);
    is_read = (a_func_r == gcm_pkg::FUNC_READ) && a_rd_ok_r;

    // room in the output queue for the result of a final slot
    occ       = 3'(fill_r) + 3'(w_res_r) - 3'(pop);
    credit_ok = occ < 3'd2;

    issue     = a_vld_r && !clr_act_r && (!a_last || credit_ok);
    a_fin     = issue && a_last;
    mem_rd_en = issue && (is_bump || is_read);
  end

  // job control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_acc) begin
      a_vld_r <= 1'b1;
    end else if (a_fin) begin
      a_vld_r <= 1'b0;
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_func_r    <= in_func;
      a_q_r       <= q;
      a_left_r    <= left_r;
      a_rd_ok_r   <= rd_ok;
      a_rd_addr_r <= {in_row_bin[BW-1:0], in_col_bin[BW-1:0]};
      a_done_r    <= col_wrap && row_wrap;
      if (in_func == gcm_pkg::FUNC_PIXEL) begin
        a_mask_r <= {{2{row_pos_r != '0}}, {2{col_pos_r != '0}}};
      end else begin
        a_mask_r <= '0;
      end
    end else if (issue) begin
      a_mask_r <= mask_rest;
    end
  end

  // --------------------------------------------------------------------------
  // count memory and write-back stage
  // --------------------------------------------------------------------------
  logic [CW-1:0]  cnt_mem [CNT_DEPTH];
  logic [CW-1:0]  cnt_rd_r;
  logic           w_bump_r;
  logic [CAW-1:0] w_addr_r;
  logic           w_func_r;
  logic           w_rd_ok_r;
  logic           w_done_r;
  logic           lw_vld_r;
  logic [CAW-1:0] lw_addr_r;
  logic [CW-1:0]  lw_data_r;
  logic [CW-1:0]  w_data;
  logic [CW-1:0]  w_inc;
  logic           cnt_we;
  logic [CAW-1:0] cnt_wa;
  logic [CW-1:0]  cnt_wd;
  gcm_pkg::res_t  w_res;

  always_comb begin
    // the write from the previous write-back is not yet seen by this read
    if (lw_vld_r && (lw_addr_r == w_addr_r)) begin
      w_data = lw_data_r;
    end else begin
      w_data = cnt_rd_r;
    end
    w_inc = (w_data == '1) ? w_data : w_data + CW'(1);

    cnt_we = clr_act_r || w_bump_r;
    cnt_wa = clr_act_r ? clr_cnt_r[CAW-1:0] : w_addr_r;
    cnt_wd = clr_act_r ? '0 : w_inc;

    w_res.count      = ((w_func_r == gcm_pkg::FUNC_READ) && w_rd_ok_r) ? w_data : '0;
    w_res.frame_done = (w_func_r == gcm_pkg::FUNC_PIXEL) && w_done_r;
  end

  // count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (mem_rd_en) begin
      cnt_rd_r <= cnt_mem[op_addr];
    end
  end

  // write-back stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_res_r  <= 1'b0;
      w_bump_r <= 1'b0;
      lw_vld_r <= 1'b0;
    end else begin
      w_res_r  <= a_fin;
      w_bump_r <= issue && is_bump;
      lw_vld_r <= w_bump_r;
    end
  end

  // write-back stage payload
  always_ff @(posedge clk) begin
    w_addr_r  <= op_addr;
    w_func_r  <= a_func_r;
    w_rd_ok_r <= a_rd_ok_r;
    w_done_r  <= a_done_r;
    lw_addr_r <= w_addr_r;
    lw_data_r <= w_inc;
  end

  // --------------------------------------------------------------------------
  // two-beat output queue
  // --------------------------------------------------------------------------
  gcm_pkg::res_t head_r;
  gcm_pkg::res_t tail_r;

  assign out_valid      = fill_r != 2'd0;
  assign pop            = out_valid && !out_stall;
  assign out_count      = head_r.count;
  assign out_frame_done = head_r.frame_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_r + 2'(w_res_r) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (w_res_r && ((fill_r == 2'd0) || ((fill_r == 2'd1) && pop))) begin
      head_r <= w_res;
    end else if (pop) begin
      head_r <= tail_r;
    end
    if (w_res_r && (((fill_r == 2'd1) && !pop) || ((fill_r == 2'd2) && pop))) begin
      tail_r <= w_res;
    end
  end

`ifndef NO_ASSERTIONS
  // a result never lands on a full queue that is not draining
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (w_res_r && (fill_r == 2'd2)) |-> pop)
    else $error("output queue overflow");

  // no item is taken during a clearing pass
  a_no_acc_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_act_r |-> !in_acc)
    else $error("item accepted during clearing pass");

  // clearing writes and count updates never share the write port
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    clr_act_r |-> !w_bump_r && !mem_rd_en)
    else $error("count update during clearing pass");

  // the end of a pass leaves the counts marked clean
  a_clean_after: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_act_r) |-> clean_r)
    else $error("clearing pass ended without clean mark");
`endif

endmodule

### tb/gcm_cooccurrence_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_cooccurrence_checker
// Watches the pixel/read channel, the result channel and register writes of
// the co-occurrence unit, keeps its own histogram, line store and raster
// position, and compares every result beat against the predicted one.
// ----------------------------------------------------------------------------
module gcm_cooccurrence_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_func,
  input  logic [gcm_pkg::PIX_W-1:0]   in_pixel,
  input  logic [gcm_pkg::BIN_W-1:0]   in_row_bin,
  input  logic [gcm_pkg::BIN_W-1:0]   in_col_bin,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [gcm_pkg::CNT_W-1:0]   out_count,
  input  logic                        out_frame_done,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [gcm_pkg::APB_AW-1:0]  paddr,
  input  logic [gcm_pkg::APB_DW-1:0]  pwdata,
  output int                          mismatches,
  output int                          outstanding
);

  // shadow registers
  logic [gcm_pkg::BIN_W-1:0] bins_reg;
  logic [gcm_pkg::DIM_W-1:0] width_reg;
  logic [gcm_pkg::DIM_W-1:0] height_reg;

  // shadow histogram (sparse), line store and raster position
  logic [gcm_pkg::CNT_W-1:0] pair_counts [int unsigned];
  logic [gcm_pkg::BIN_W-1:0] upper_bins [gcm_pkg::DEF_MAX_WIDTH];
  logic [gcm_pkg::BIN_W-1:0] left_q;
  int unsigned               row_at;
  int unsigned               col_at;

  // results still owed by the unit, oldest first
  gcm_pkg::res_t owed_results [$];

  // effective bin count: zero acts as one bin
  function automatic int unsigned live_levels();
    int unsigned b;
    b = bins_reg;
    if (b < 1) b = 1;
    if (b > gcm_pkg::DEF_MAX_BINS) b = gcm_pkg::DEF_MAX_BINS;
    return b;
  endfunction

  function automatic int unsigned fit_size(int unsigned v, int unsigned most);
    if (v < 1) return 1;
    if (v > most) return most;
    return v;
  endfunction

  // saturating increment of one histogram entry
  function automatic void count_hit(int unsigned a, int unsigned b);
    int unsigned key;
    key = a * gcm_pkg::DEF_MAX_BINS + b;
    if (a >= gcm_pkg::DEF_MAX_BINS || b >= gcm_pkg::DEF_MAX_BINS) return;
    if (!pair_counts.exists(key)) pair_counts[key] = '0;
    if (pair_counts[key] != '1) pair_counts[key] = pair_counts[key] + 1'b1;
  endfunction

  // advance the shadow state by one beat and return the result it owes
  function automatic gcm_pkg::res_t next_result(logic func,
                                                logic [gcm_pkg::PIX_W-1:0] pix,
                                                logic [gcm_pkg::BIN_W-1:0] rb,
                                                logic [gcm_pkg::BIN_W-1:0] cb);
    gcm_pkg::res_t res;
    int unsigned   levels;
    int unsigned   w;
    int unsigned   h;
    int unsigned   q;
    int unsigned   col;
    int unsigned   key;
    res    = '0;
    levels = live_levels();
    if (func == gcm_pkg::FUNC_READ) begin
      key = rb * gcm_pkg::DEF_MAX_BINS + cb;
      if (bins_reg != 0 && rb < levels && cb < levels && pair_counts.exists(key))
        res.count = pair_counts[key];
      return res;
    end
    w   = fit_size(width_reg, gcm_pkg::DEF_MAX_WIDTH);
    h   = fit_size(height_reg, gcm_pkg::DEF_MAX_HEIGHT);
    q   = (2 * pix * (levels - 1) + 255) / 510;
    col = (col_at >= gcm_pkg::DEF_MAX_WIDTH) ? gcm_pkg::DEF_MAX_WIDTH - 1 : col_at;
    // first pixel of a frame starts from an empty histogram
    if (row_at == 0 && col_at == 0) pair_counts.delete();
    if (col_at > 0) begin
      count_hit(left_q, q);
      count_hit(q, left_q);
    end
    if (row_at > 0) begin
      count_hit(upper_bins[col], q);
      count_hit(q, upper_bins[col]);
    end
    upper_bins[col] = gcm_pkg::BIN_W'(q);
    left_q          = gcm_pkg::BIN_W'(q);
    // raster advance, compared against the sizes in force now
    col_at++;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
      if (row_at >= h) begin
        row_at         = 0;
        res.frame_done = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    gcm_pkg::res_t want;
    int            bad;
    bad = 0;
    if (!rst_n) begin
      bins_reg   = gcm_pkg::RST_BIN_COUNT;
      width_reg  = gcm_pkg::RST_IMAGE_WIDTH;
      height_reg = gcm_pkg::RST_IMAGE_HEIGHT;
      pair_counts.delete();
      foreach (upper_bins[i]) upper_bins[i] = '0;
      left_q = '0;
      row_at = 0;
      col_at = 0;
      owed_results.delete();
      outstanding <= 0;
      mismatches  <= 0;
    end else begin
      // result beat against the oldest owed result
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result beat with nothing owed: count %0d frame_done %0b",
                 out_count, out_frame_done);
          bad++;
        end else begin
          want = owed_results.pop_front();
          if (out_count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_count);
            bad++;
          end
          if (out_frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, actual %0b", want.frame_done,
                   out_frame_done);
            bad++;
          end
        end
      end
      // accepted input beat sees the registers from before this edge
      if (in_valid && !in_stall)
        owed_results.push_back(next_result(in_func, in_pixel, in_row_bin, in_col_bin));
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (gcm_pkg::cfg_reg_t'(paddr[3:2]))
          gcm_pkg::REG_BIN_COUNT:    bins_reg   = pwdata[gcm_pkg::BIN_W-1:0];
          gcm_pkg::REG_IMAGE_WIDTH:  width_reg  = pwdata[gcm_pkg::DIM_W-1:0];
          gcm_pkg::REG_IMAGE_HEIGHT: height_reg = pwdata[gcm_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
      outstanding <= owed_results.size();
      if (bad != 0) mismatches <= mismatches + bad;
    end
  end

endmodule

### tb/tb_gray_cooccurrence_matrix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gray_cooccurrence_matrix_unit
// Drives pixel and read beats through the co-occurrence unit over a series of
// register settings (bin count and image size at their extremes and between),
// with random gaps and output stalls; the checker beside the unit predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_gray_cooccurrence_matrix_unit;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_valid   = 1'b0;
  logic                         in_func    = gcm_pkg::FUNC_PIXEL;
  logic [gcm_pkg::PIX_W-1:0]    in_pixel   = '0;
  logic [gcm_pkg::BIN_W-1:0]    in_row_bin = '0;
  logic [gcm_pkg::BIN_W-1:0]    in_col_bin = '0;
  logic                         out_stall  = 1'b0;
  logic                         psel       = 1'b0;
  logic                         penable    = 1'b0;
  logic                         pwrite     = 1'b0;
  logic [gcm_pkg::APB_AW-1:0]   paddr      = '0;
  logic [gcm_pkg::APB_DW-1:0]   pwdata     = '0;
  logic                         in_stall;
  logic                         out_valid;
  logic [gcm_pkg::CNT_W-1:0]    out_count;
  logic                         out_frame_done;
  logic [gcm_pkg::APB_DW-1:0]   prdata;
  logic                         pready;
  int                           mismatches;
  int                           outstanding;
  int unsigned                  stall_run = 0;

  gray_cooccurrence_matrix_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_pixel(in_pixel), .in_row_bin(in_row_bin), .in_col_bin(in_col_bin),
    .out_valid(out_valid), .out_stall(out_stall), .out_count(out_count),
    .out_frame_done(out_frame_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gcm_cooccurrence_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_pixel(in_pixel), .in_row_bin(in_row_bin), .in_col_bin(in_col_bin),
    .out_valid(out_valid), .out_stall(out_stall), .out_count(out_count),
    .out_frame_done(out_frame_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result-side back-pressure: short bursts, quiet stretches, rare long holds
  always @(posedge clk) begin : stall_gen
    int unsigned roll;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 6);
      end else if (roll < 85) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 3);
      end else if (roll < 95) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(20, 120);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(10, 40);
      end
    end
  end

  // one beat, held until the unit takes it
  task automatic put_beat(input logic func, input logic [gcm_pkg::PIX_W-1:0] pix,
                          input logic [gcm_pkg::BIN_W-1:0] rb,
                          input logic [gcm_pkg::BIN_W-1:0] cb);
    in_valid   <= 1'b1;
    in_func    <= func;
    in_pixel   <= pix;
    in_row_bin <= rb;
    in_col_bin <= cb;
    do @(posedge clk); while (in_stall);
  endtask

  // random gap before the next beat, mostly none or short
  task automatic idle_gap();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (roll < 50) return;
    len = (roll < 90) ? $urandom_range(1, 3) : $urandom_range(15, 60);
    in_valid <= 1'b0;
    repeat (len) @(posedge clk);
  endtask

  // wait until every owed result is out and the count memory has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic reg_write(input gcm_pkg::cfg_reg_t idx,
                           input logic [gcm_pkg::APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // rough bin of a pixel, so reads mostly land on populated entries
  function automatic logic [gcm_pkg::BIN_W-1:0] bin_guess(
      logic [gcm_pkg::PIX_W-1:0] pix, logic [gcm_pkg::BIN_W-1:0] bc);
    logic [gcm_pkg::BIN_W-1:0] g;
    g = gcm_pkg::BIN_W'((int'(pix) * int'(bc)) >> 8);
    if (g != 0 && $urandom_range(0, 1) == 1) g = g - 1'b1;
    return g;
  endfunction

  // one register setting, then a mix of pixels drawn from a small palette,
  // random pixels and reads
  task automatic run_phase(input logic [gcm_pkg::BIN_W-1:0] bc,
                           input logic [gcm_pkg::DIM_W-1:0] w,
                           input logic [gcm_pkg::DIM_W-1:0] h,
                           input int unsigned beats);
    logic [gcm_pkg::PIX_W-1:0] palette [4];
    logic [gcm_pkg::PIX_W-1:0] pix;
    logic [gcm_pkg::BIN_W-1:0] rb;
    logic [gcm_pkg::BIN_W-1:0] cb;
    bit                        calm;
    settle();
    reg_write(gcm_pkg::REG_BIN_COUNT, gcm_pkg::APB_DW'(bc));
    reg_write(gcm_pkg::REG_IMAGE_WIDTH, gcm_pkg::APB_DW'(w));
    reg_write(gcm_pkg::REG_IMAGE_HEIGHT, gcm_pkg::APB_DW'(h));
    foreach (palette[i]) palette[i] = gcm_pkg::PIX_W'($urandom_range(0, 255));
    calm = 1'b0;
    for (int unsigned k = 0; k < beats; k++) begin
      if (k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 20) begin
        if ($urandom_range(0, 4) == 0) begin
          rb = gcm_pkg::BIN_W'($urandom_range(0, 255));
          cb = gcm_pkg::BIN_W'($urandom_range(0, 255));
        end else begin
          rb = bin_guess(palette[$urandom_range(0, 3)], bc);
          cb = bin_guess(palette[$urandom_range(0, 3)], bc);
        end
        put_beat(gcm_pkg::FUNC_READ, gcm_pkg::PIX_W'($urandom_range(0, 255)), rb, cb);
      end else begin
        pix = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 3)]
                                         : gcm_pkg::PIX_W'($urandom_range(0, 255));
        put_beat(gcm_pkg::FUNC_PIXEL, pix, gcm_pkg::BIN_W'($urandom_range(0, 255)),
                 gcm_pkg::BIN_W'($urandom_range(0, 255)));
      end
      if (!calm) idle_gap();
    end
  endtask

  initial begin : stimulus
    logic [gcm_pkg::PIX_W-1:0] frame_px [12];
    frame_px = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd1, 8'd254, 8'd64, 8'd200,
                 8'd255, 8'd0, 8'd127, 8'd128};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a 4x3 frame at the widest bin count, covering first row and
    // first column, extreme pixels and an equal-bin pair
    reg_write(gcm_pkg::REG_BIN_COUNT, 32'd255);
    reg_write(gcm_pkg::REG_IMAGE_WIDTH, 32'd4);
    reg_write(gcm_pkg::REG_IMAGE_HEIGHT, 32'd3);
    for (int i = 0; i < 12; i++) begin
      if (i == 4) begin
        put_beat(gcm_pkg::FUNC_READ, 8'hFF, 8'd127, 8'd127);
        put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd0, 8'd254);
      end
      put_beat(gcm_pkg::FUNC_PIXEL, frame_px[i], 8'h00, 8'hFF);
    end
    // finished frame stays readable; out-of-range bins read zero
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd254, 8'd0);
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd255, 8'd0);
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd0, 8'd255);
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd127, 8'd127);
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd254, 8'd254);
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd1, 8'd1);
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd0, 8'd0);
    // zero bins reads nothing, one bin reads only the first entry
    settle();
    reg_write(gcm_pkg::REG_BIN_COUNT, 32'd0);
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd0, 8'd0);
    settle();
    reg_write(gcm_pkg::REG_BIN_COUNT, 32'd1);
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd0, 8'd0);
    put_beat(gcm_pkg::FUNC_READ, 8'h00, 8'd1, 8'd0);

    // random phases; sizes keep frame starts (and their clearing) few
    run_phase(8'd2, 11'd16, 11'd8, 380);
    run_phase(8'd0, 11'd0, 11'd2047, 150);
    run_phase(8'd1, 11'd2047, 11'd0, 150);
    run_phase(gcm_pkg::BIN_W'($urandom_range(3, 254)),
              gcm_pkg::DIM_W'($urandom_range(12, 30)),
              gcm_pkg::DIM_W'($urandom_range(10, 20)), 250);
    run_phase(8'd255, 11'd1024, 11'd1024, 200);
    run_phase(8'd128, 11'd7, gcm_pkg::DIM_W'($urandom_range(20, 1024)), 250);
    run_phase(gcm_pkg::BIN_W'($urandom_range(2, 255)),
              gcm_pkg::DIM_W'($urandom_range(3, 1024)),
              gcm_pkg::DIM_W'($urandom_range(50, 1024)), 200);

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // hard stop for a hung handshake
  initial begin
    #(250_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
rtl/gcm_pkg.sv
rtl/gray_cooccurrence_matrix_unit.sv
tb/gcm_cooccurrence_checker.sv
tb/tb_gray_cooccurrence_matrix_unit.sv
